/* design/pcicp_pkg.sv */
// ----------------------------------------------------------------------------
// PNG cICP scanner package
// Shared types and constants for the PNG cICP chunk scanner.
// ----------------------------------------------------------------------------
package pcicp_pkg;

    localparam int unsigned SIG_LEN    = 8;
    localparam int unsigned OFF_W      = 33;
    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [31:0] TYPE_IDAT  = 32'h4944_4154;
    localparam logic [31:0] TYPE_CICP  = 32'h6349_4350;

    localparam logic [1:0] PHASE_SCAN = 2'd0;
    localparam logic [1:0] PHASE_STOP = 2'd1;
    localparam logic [1:0] PHASE_FAIL = 2'd2;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_TRUNCATED   = 2'd1;
    localparam logic [1:0] STATUS_INVALID     = 2'd2;
    localparam logic [1:0] STATUS_UNSUPPORTED = 2'd3;

    typedef struct packed {
        logic       present;
        logic       full_range;
        logic [7:0] transfer;
        logic [7:0] primaries;
    } t_cicp_fields;

    localparam t_cicp_fields CICP_FIELDS_RESET = '{
        present:    1'b0,
        full_range: 1'b1,
        transfer:   8'd13,
        primaries:  8'd1
    };

    typedef struct packed {
        logic [1:0]   phase;
        logic         truncated;
        t_cicp_fields fields;
    } t_verdict_in;

endpackage

/* design/png_cicp_chunk_scanner.sv */
// ----------------------------------------------------------------------------
// PNG cICP chunk scanner
// Walks the chunks of a PNG byte stream, validates a cICP chunk and reports
// its color codes once per file.
//
// The input channel carries one file byte per item in s_tdata[7:0], with
// s_tlast on the final byte of the file. The first eight bytes are skipped as
// the signature, then each chunk's length, type, data and CRC are tracked
// until a whole IDAT chunk has gone by or a cICP chunk fails its checks.
// Unless stalled, a byte is taken every cycle; the CRC-32 advances one byte
// per cycle and the chunk bookkeeping keeps a 33-bit offset against precomputed
// bounds. The item with s_tlast produces exactly one result item on the output
// channel, visible on m_tvalid the cycle after it is accepted; other bytes
// produce nothing. After that item all scan state returns to its reset value
// for the next file. The result sits in an output register: the block keeps
// taking bytes while it waits, and only stops taking bytes (s_tready low)
// when a result is held and m_tready is low. Synchronous active-low reset
// clears the scan state and drops m_tvalid.
// ----------------------------------------------------------------------------
module png_cicp_chunk_scanner
    import pcicp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [1:0] status, [2] cicp_present,
                                   // [10:3] primaries_code, [18:11] transfer_code,
                                   // [19] full_range, [23:20] zero
);

    logic [3:0]         r_sig, n_sig;
    logic [OFF_W-1:0]   r_off, n_off;
    logic [OFF_W-1:0]   r_data_end, n_data_end;
    logic [OFF_W-1:0]   r_chunk_end, n_chunk_end;
    logic [31:0]        r_len, n_len;
    logic [31:0]        r_type, n_type;
    logic [31:0]        r_crc, n_crc;
    logic [31:0]        r_stored, n_stored;
    logic [31:0]        r_held, n_held;
    t_cicp_fields       r_fields, n_fields;
    logic [1:0]         r_phase, n_phase;
    logic               r_out_valid;
    logic [23:0]        r_out_data;

    logic               accept;
    logic [OFF_W-1:0]   off_next;
    logic               past_header;
    logic               in_data;
    logic [31:0]        crc_stepped;
    logic               cicp_bad;
    t_verdict_in        verdict_in;
    logic [1:0]         status;

    assign s_tready = !r_out_valid || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

    assign off_next    = r_off + OFF_W'(1);
    assign past_header = (r_off >= OFF_W'(4));
    assign in_data     = past_header && (r_off < r_data_end);

    pcicp_crc_step u_crc (
        .i_crc  (r_crc),
        .i_byte (s_tdata),
        .o_crc  (crc_stepped)
    );

    always_comb begin
        n_sig       = r_sig;
        n_off       = r_off;
        n_data_end  = r_data_end;
        n_chunk_end = r_chunk_end;
        n_len       = r_len;
        n_type      = r_type;
        n_crc       = r_crc;
        n_stored    = r_stored;
        n_held      = r_held;
        n_fields    = r_fields;
        n_phase     = r_phase;
        cicp_bad    = 1'b0;

        if (r_sig < 4'(SIG_LEN)) begin
            n_sig = r_sig + 4'd1;
        end else if (r_phase == PHASE_SCAN) begin
            if (!past_header) begin
                n_len = {r_len[23:0], s_tdata};
                if (r_off[1:0] == 2'd3) begin
                    n_data_end  = {1'b0, n_len} + OFF_W'(8);
                    n_chunk_end = {1'b0, n_len} + OFF_W'(12);
                end
            end else if (r_off < OFF_W'(8)) begin
                n_type = {r_type[23:0], s_tdata};
            end
            if (in_data) begin
                n_crc = crc_stepped;
            end
            if (in_data && r_off >= OFF_W'(8) && r_off < OFF_W'(12)) begin
                n_held = {r_held[23:0], s_tdata};
            end
            if (past_header && !in_data) begin
                n_stored = {r_stored[23:0], s_tdata};
            end
            if (past_header && off_next == r_chunk_end) begin
                cicp_bad = (r_len != 32'd4) || r_fields.present
                        || (~r_crc != n_stored) || (r_held[15:8] != 8'd0)
                        || (r_held[7:0] > 8'd1);
                if (r_type == TYPE_IDAT) begin
                    n_phase = PHASE_STOP;
                end else if (r_type == TYPE_CICP) begin
                    if (cicp_bad) begin
                        n_phase = PHASE_FAIL;
                    end else begin
                        n_fields = '{
                            present:    1'b1,
                            full_range: r_held[0],
                            transfer:   r_held[23:16],
                            primaries:  r_held[31:24]
                        };
                    end
                end
                n_off = '0;
                n_crc = CRC_INIT;
            end else begin
                n_off = off_next;
            end
        end
    end

    always_comb begin
        verdict_in.phase     = n_phase;
        verdict_in.truncated = (n_off >= OFF_W'(12));
        verdict_in.fields    = n_fields;
    end

    pcicp_verdict u_verdict (
        .i_verdict (verdict_in),
        .o_status  (status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sig       <= '0;
            r_off       <= '0;
            r_data_end  <= '0;
            r_chunk_end <= '0;
            r_crc       <= CRC_INIT;
            r_fields    <= CICP_FIELDS_RESET;
            r_phase     <= PHASE_SCAN;
        end else if (accept) begin
            if (s_tlast) begin
                r_sig       <= '0;
                r_off       <= '0;
                r_data_end  <= '0;
                r_chunk_end <= '0;
                r_crc       <= CRC_INIT;
                r_fields    <= CICP_FIELDS_RESET;
                r_phase     <= PHASE_SCAN;
            end else begin
                r_sig       <= n_sig;
                r_off       <= n_off;
                r_data_end  <= n_data_end;
                r_chunk_end <= n_chunk_end;
                r_crc       <= n_crc;
                r_fields    <= n_fields;
                r_phase     <= n_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_len    <= n_len;
            r_type   <= n_type;
            r_stored <= n_stored;
            r_held   <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && s_tlast) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && s_tlast) begin
            r_out_data <= {4'd0, n_fields.full_range, n_fields.transfer,
                           n_fields.primaries, n_fields.present, status};
        end
    end

    a_sig_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sig <= 4'(SIG_LEN))
        else $error("signature counter ran past the signature");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
        else $error("final byte did not produce a result item");

    a_halt_clears_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PHASE_SCAN) |-> (r_off == '0))
        else $error("chunk offset nonzero after scanning stopped");

    a_no_result_mid_file: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!m_tvalid && !(s_tvalid && s_tready && s_tlast)) |=> !m_tvalid)
        else $error("result item appeared without a final byte");

endmodule

/* design/pcicp_crc_step.sv */
// ----------------------------------------------------------------------------
// CRC-32 byte step
// Advances a reflected CRC-32 register by one byte, all eight bits at once.
// ----------------------------------------------------------------------------
module pcicp_crc_step
    import pcicp_pkg::*;
(
    input  logic [31:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [31:0] o_crc
);

    always_comb begin
        logic [31:0] c;
        c = i_crc ^ {24'd0, i_byte};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        o_crc = c;
    end

endmodule

/* design/pcicp_verdict.sv */
// ----------------------------------------------------------------------------
// cICP verdict
// Turns the scan outcome and the held cICP codes into the stream status.
// ----------------------------------------------------------------------------
module pcicp_verdict
    import pcicp_pkg::*;
(
    input  t_verdict_in i_verdict,
    output logic [1:0]  o_status
);

    localparam logic [7:0] CP_BT709   = 8'd1;
    localparam logic [7:0] CP_BT2020  = 8'd9;
    localparam logic [7:0] CP_P3D65   = 8'd12;
    localparam logic [7:0] TF_BT709   = 8'd1;
    localparam logic [7:0] TF_GAMMA22 = 8'd4;
    localparam logic [7:0] TF_GAMMA28 = 8'd5;
    localparam logic [7:0] TF_BT601   = 8'd6;
    localparam logic [7:0] TF_LINEAR  = 8'd8;
    localparam logic [7:0] TF_SRGB    = 8'd13;
    localparam logic [7:0] TF_BT2020A = 8'd14;
    localparam logic [7:0] TF_BT2020B = 8'd15;
    localparam logic [7:0] TF_PQ      = 8'd16;
    localparam logic [7:0] TF_HLG     = 8'd18;

    logic prim_ok;
    logic tf_ok;
    logic combo_ok;

    always_comb begin
        case (i_verdict.fields.primaries) inside
            CP_BT709, CP_BT2020, CP_P3D65: prim_ok = 1'b1;
            default:                       prim_ok = 1'b0;
        endcase
        case (i_verdict.fields.transfer) inside
            TF_BT709, TF_GAMMA22, TF_GAMMA28, TF_BT601, TF_LINEAR, TF_SRGB,
            TF_BT2020A, TF_BT2020B, TF_PQ, TF_HLG: tf_ok = 1'b1;
            default:                               tf_ok = 1'b0;
        endcase
        combo_ok = (i_verdict.fields.transfer != TF_HLG)
                || (i_verdict.fields.primaries == CP_BT2020);
    end

    always_comb begin
        if (i_verdict.phase == PHASE_FAIL) begin
            o_status = STATUS_INVALID;
        end else if (i_verdict.phase == PHASE_SCAN && i_verdict.truncated) begin
            o_status = STATUS_TRUNCATED;
        end else if (i_verdict.fields.present && !(prim_ok && tf_ok && combo_ok)) begin
            o_status = STATUS_UNSUPPORTED;
        end else begin
            o_status = STATUS_OK;
        end
    end

endmodule
